// ===== rtl/tlsba_pkg.sv =====
`default_nettype none

package tlsba_pkg;

   localparam int ADDR_W          = 48;
   localparam int GROUP_COUNT     = 8;
   localparam int SLOTS_PER_GROUP = 16;
   // window size must be a power of two: decode and offset use shifts
   localparam int WINDOW_BYTES    = 65536;

   localparam int WIN_SHIFT = $clog2(WINDOW_BYTES);
   localparam int SLOT_W    = $clog2(SLOTS_PER_GROUP);
   localparam int GRP_W     = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

   typedef logic [ADDR_W-1:0]          addr_type;
   typedef logic [SLOTS_PER_GROUP-1:0] slot_map_type;

   localparam logic MODE_ACQUIRE = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NO_SLOT  = 3'd1,
      ST_NO_BASE  = 3'd2,
      ST_BAD_ADDR = 3'd3,
      ST_NOT_USED = 3'd4
   } status_type;

   typedef struct packed {
      logic     mode;
      logic     is_privileged;
      addr_type release_addr;
      addr_type offered_base;
   } req_type;

   typedef struct packed {
      status_type status;
      addr_type   window_addr;
      addr_type   freed_base;
      logic       base_consumed;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/two_level_slot_bitmap_allocator.sv =====
`default_nettype none

// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_ready | req_data (mode, privilege, addresses)
// rsp     | out       | rsp_valid / rsp_ready | rsp_data (status, addresses, consumed)
//
// A result is registered after its request transfer: the groups are scanned in turn,
// until one settles the request, through the shared adder and slot finder, then the
// finish state updates the use map and loads the result register; req_ready returns
// as the result register loads. Synchronous reset clears all group bases and use maps at once.
// req_ready is high only while idle; a result held by rsp_ready stalls the
// finish state of the next item until the output register is free.
module two_level_slot_bitmap_allocator (
   input  wire  logic               clock,
   input  wire  logic               reset,
   input  wire  logic               req_valid,
   output logic                     req_ready,
   input  wire  tlsba_pkg::req_type req_data,
   output logic                     rsp_valid,
   input  wire  logic               rsp_ready,
   output tlsba_pkg::rsp_type       rsp_data
);
   import tlsba_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_type;

   state_type    state_ff;
   addr_type     grp_base_ff [GROUP_COUNT];
   slot_map_type used_ff     [GROUP_COUNT];
   logic         mode_ff;
   logic         priv_ff;
   addr_type     addr_ff;
   addr_type     offer_ff;
   logic [GRP_W-1:0]  grp_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic         hit_ff;
   logic         consumed_ff;
   status_type   status_ff;
   logic         rsp_valid_ff;
   rsp_type      rsp_data_ff;

   addr_type     cur_base;
   slot_map_type cur_used;
   slot_map_type avail;
   slot_map_type slot_bit;
   slot_map_type cleared_map;
   logic         free_found;
   logic [SLOT_W-1:0] free_idx;
   logic         grp_full;
   logic         base_ok;
   logic         last_grp;
   addr_type     add_a;
   addr_type     add_b;
   logic         add_sub;
   logic [ADDR_W:0] add_sum;
   addr_type     rel_off;
   logic         rel_match;
   logic         rel_aligned;
   logic [SLOT_W-1:0] rel_id;
   logic         fin_go;
   logic         fin_clear;
   logic         fin_free_grp;
   rsp_type      fin_rsp;

   assign cur_base = grp_base_ff[grp_ff];
   assign cur_used = used_ff[grp_ff];
   assign grp_full = &cur_used;
   assign base_ok  = (cur_base != '0) || (offer_ff != '0);
   assign last_grp = (grp_ff == GRP_W'(GROUP_COUNT-1));

   // slot 0 of group 0 is kept for the privileged requester
   always_comb begin
      avail = ~cur_used;
      if (grp_ff == '0 && !priv_ff) begin
         avail[0] = 1'b0;
      end
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS_PER_GROUP-1; i >= 0; i--) begin
         if (avail[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   // scan: offset of the release address; finish: base plus slot offset
   always_comb begin
      add_a   = addr_ff;
      add_b   = cur_base;
      add_sub = 1'b1;
      if (state_ff == S_FINISH) begin
         add_a   = cur_base;
         add_b   = addr_type'({slot_ff, {WIN_SHIFT{1'b0}}});
         add_sub = 1'b0;
      end
   end

   tlsba_addsub u_addsub (
      .opa (add_a),
      .opb (add_b),
      .sub (add_sub),
      .sum (add_sum)
   );

   assign rel_off     = add_sum[ADDR_W-1:0];
   assign rel_match   = (cur_base != '0) && add_sum[ADDR_W] &&
                        ((rel_off >> WIN_SHIFT) < addr_type'(SLOTS_PER_GROUP));
   assign rel_aligned = (rel_off[WIN_SHIFT-1:0] == '0);
   assign rel_id      = rel_off[WIN_SHIFT +: SLOT_W];

   assign fin_go = !rsp_valid_ff || rsp_ready;

   always_comb begin
      slot_bit        = '0;
      slot_bit[slot_ff] = 1'b1;
      cleared_map     = cur_used & ~slot_bit;
      fin_clear       = hit_ff && (mode_ff == MODE_RELEASE) && ((cur_used & slot_bit) != '0);
      fin_free_grp    = fin_clear && (grp_ff != '0) && (cleared_map == '0);
      fin_rsp.status        = status_ff;
      fin_rsp.window_addr   = '0;
      fin_rsp.freed_base    = '0;
      fin_rsp.base_consumed = consumed_ff;
      if (hit_ff && mode_ff == MODE_ACQUIRE) begin
         fin_rsp.window_addr = add_sum[ADDR_W-1:0];
      end
      if (hit_ff && mode_ff == MODE_RELEASE && !fin_clear) begin
         fin_rsp.status = ST_NOT_USED;
      end
      if (fin_free_grp) begin
         fin_rsp.freed_base = cur_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int g = 0; g < GROUP_COUNT; g++) begin
            grp_base_ff[g] <= '0;
            used_ff[g]     <= '0;
         end
      end else begin
         // drop the transfer unless a new result loads in the same cycle
         if (rsp_valid_ff && rsp_ready && !(state_ff == S_FINISH && fin_go)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  mode_ff     <= req_data.mode;
                  priv_ff     <= req_data.is_privileged;
                  addr_ff     <= req_data.release_addr;
                  offer_ff    <= req_data.offered_base;
                  grp_ff      <= '0;
                  hit_ff      <= 1'b0;
                  consumed_ff <= 1'b0;
                  state_ff    <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (mode_ff == MODE_ACQUIRE) begin
                  if (!grp_full && cur_base == '0) begin
                     consumed_ff <= 1'b1;
                  end
                  if (!grp_full && !base_ok) begin
                     status_ff <= ST_NO_BASE;
                     state_ff  <= S_FINISH;
                  end else if (!grp_full && free_found) begin
                     if (cur_base == '0) begin
                        grp_base_ff[grp_ff] <= offer_ff;
                     end
                     slot_ff   <= free_idx;
                     hit_ff    <= 1'b1;
                     status_ff <= ST_OK;
                     state_ff  <= S_FINISH;
                  end else begin
                     // group 0 may still take the base with only the kept slot free
                     if (!grp_full && cur_base == '0) begin
                        grp_base_ff[grp_ff] <= offer_ff;
                     end
                     if (last_grp) begin
                        status_ff <= ST_NO_SLOT;
                        state_ff  <= S_FINISH;
                     end else begin
                        grp_ff <= grp_ff + 1'b1;
                     end
                  end
               end else begin
                  if (rel_match) begin
                     slot_ff   <= rel_id;
                     hit_ff    <= rel_aligned;
                     status_ff <= rel_aligned ? ST_OK : ST_BAD_ADDR;
                     state_ff  <= S_FINISH;
                  end else if (last_grp) begin
                     status_ff <= ST_BAD_ADDR;
                     state_ff  <= S_FINISH;
                  end else begin
                     grp_ff <= grp_ff + 1'b1;
                  end
               end
            end
            S_FINISH: begin
               if (fin_go) begin
                  if (hit_ff && mode_ff == MODE_ACQUIRE) begin
                     used_ff[grp_ff] <= cur_used | slot_bit;
                  end
                  if (fin_clear) begin
                     used_ff[grp_ff] <= cleared_map;
                  end
                  if (fin_free_grp) begin
                     grp_base_ff[grp_ff] <= '0;
                  end
                  rsp_data_ff  <= fin_rsp;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/tlsba_addsub.sv =====
`default_nettype none

// Shared adder: window address on acquire, offset from group base on release.
module tlsba_addsub (
   input  wire tlsba_pkg::addr_type      opa,
   input  wire tlsba_pkg::addr_type      opb,
   input  wire logic                     sub,
   output logic [tlsba_pkg::ADDR_W:0]    sum
);
   import tlsba_pkg::*;

   addr_type opb_x;

   assign opb_x = sub ? ~opb : opb;
   // carry out of a subtract is high when there is no borrow (opa >= opb)
   assign sum = {1'b0, opa} + {1'b0, opb_x} + (ADDR_W+1)'(sub);

endmodule

`default_nettype wire

// ===== rtl/tlsba_checker.sv =====
`default_nettype none

module tlsba_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire tlsba_pkg::rsp_type rsp_data
);
   import tlsba_pkg::*;

   // one item at a time: a transfer in closes the input until done
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready high right after a request transfer");

   // any failure carries no addresses
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |->
         (rsp_data.window_addr == '0 && rsp_data.freed_base == '0))
      else $error("failed response carries an address");

   // a base offer is only tried on acquire, which never frees a group
   a_consumed_no_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.base_consumed) |-> (rsp_data.freed_base == '0))
      else $error("freed base reported with base consumed");

   a_no_base_consumed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_NO_BASE) |-> rsp_data.base_consumed)
      else $error("base unavailable without base consumed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response dropped or changed");

endmodule

bind two_level_slot_bitmap_allocator tlsba_checker u_tlsba_checker (.*);

`default_nettype wire

// ===== test/tb_two_level_slot_bitmap_allocator.sv =====
`timescale 1ns / 1ps

module tb_two_level_slot_bitmap_allocator;

   import tlsba_pkg::*;

   localparam int          RESET_CYCLES = 8;
   localparam int          RANDOM_ITEMS = 1400;
   localparam int          LONG_HOLD    = 300;
   localparam int          DRAIN_CYCLES = 4 * (GROUP_COUNT + 1) + 10;
   localparam int          CYCLE_LIMIT  = 500_000;
   localparam logic [63:0] GROUP_SPAN   = 64'(SLOTS_PER_GROUP) * 64'(WINDOW_BYTES);
   localparam addr_type    BASE_A       = 48'h0000_1230_0000;
   localparam addr_type    TOP_BASE     = 48'hFFFF_FFF8_0000;

   typedef enum int {
      RDY_ALWAYS,
      RDY_COIN,
      RDY_SPARSE,
      RDY_PERIODIC
   } ready_style_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // shadow copy of the allocator state
   addr_type     model_base [GROUP_COUNT];
   slot_map_type model_map  [GROUP_COUNT];

   rsp_type    pending_rsp[$];
   addr_type   live_windows[$];
   addr_type   returned_bases[$];
   status_type last_status;

   int error_count   = 0;
   int rsp_index     = 0;
   int cycle_count   = 0;
   int burst_left    = 0;
   int hold_requests = 0;
   bit no_gaps       = 1'b0;

   two_level_slot_bitmap_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ERROR: timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      for (int g = 0; g < GROUP_COUNT; g++) begin
         model_base[g] = '0;
         model_map[g]  = '0;
      end
   end

   function automatic addr_type random_addr();
      return addr_type'({$urandom, $urandom});
   endfunction

   function automatic rsp_type predict_window_op(input req_type r);
      rsp_type     p;
      logic [63:0] addr64;
      logic [63:0] off;
      logic [63:0] id;
      int          hit;
      int          slot;
      p        = '0;
      p.status = ST_NO_SLOT;
      if (r.mode == MODE_ACQUIRE) begin
         for (int g = 0; g < GROUP_COUNT; g++) begin
            if (model_map[g] == '1) continue;
            if (model_base[g] == '0) begin
               p.base_consumed = 1'b1;
               if (r.offered_base == '0) begin
                  p.status = ST_NO_BASE;
                  return p;
               end
               model_base[g] = r.offered_base;
            end
            // slot 0 of group 0 belongs to the privileged requester
            for (int s = (g == 0 && !r.is_privileged) ? 1 : 0; s < SLOTS_PER_GROUP; s++) begin
               if (!model_map[g][s]) begin
                  model_map[g][s] = 1'b1;
                  p.status        = ST_OK;
                  p.window_addr   = model_base[g] + (addr_type'(s) << WIN_SHIFT);
                  return p;
               end
            end
         end
         return p;
      end
      addr64 = 64'(r.release_addr);
      hit    = -1;
      for (int g = 0; g < GROUP_COUNT; g++) begin
         if (hit < 0 && model_base[g] != '0 && 64'(model_base[g]) <= addr64 &&
             addr64 < 64'(model_base[g]) + GROUP_SPAN)
            hit = g;
      end
      p.status = ST_BAD_ADDR;
      if (hit < 0) return p;
      off = addr64 - 64'(model_base[hit]);
      if (off % WINDOW_BYTES != 0) return p;
      id = off / WINDOW_BYTES;
      if (id >= SLOTS_PER_GROUP) return p;
      slot = int'(id);
      if (!model_map[hit][slot]) begin
         p.status = ST_NOT_USED;
         return p;
      end
      model_map[hit][slot] = 1'b0;
      if (hit != 0 && model_map[hit] == '0) begin
         p.freed_base    = model_base[hit];
         model_base[hit] = '0;
      end
      p.status = ST_OK;
      return p;
   endfunction

   function automatic req_type acquire_req(input bit priv, input addr_type offer);
      req_type r;
      r.mode          = MODE_ACQUIRE;
      r.is_privileged = priv;
      r.release_addr  = random_addr();
      r.offered_base  = offer;
      return r;
   endfunction

   function automatic req_type release_req(input addr_type addr);
      req_type r;
      r.mode          = MODE_RELEASE;
      r.is_privileged = 1'($urandom_range(0, 1));
      r.release_addr  = addr;
      r.offered_base  = random_addr();
      return r;
   endfunction

   function automatic addr_type pick_offer();
      int g;
      g = $urandom_range(0, GROUP_COUNT - 1);
      case ($urandom_range(0, 19))
         0, 1: return '0;
         2, 3: return random_addr();
         4, 5: if (returned_bases.size() != 0)
                  return returned_bases[$urandom_range(0, returned_bases.size() - 1)];
         6:    return 48'hFFFF_FFFF_0000 - (addr_type'($urandom_range(0, 15)) << WIN_SHIFT);
         7:    if (model_base[g] != '0)
                  return model_base[g] + (addr_type'($urandom_range(0, 15)) << WIN_SHIFT);
         default: ;
      endcase
      return addr_type'({$urandom_range(1, 32'h0FFF_FFFF), 20'h0_0000});
   endfunction

   function automatic addr_type pick_release_addr();
      int       sel;
      int       g;
      addr_type w;
      sel = $urandom_range(0, 19);
      g   = $urandom_range(0, GROUP_COUNT - 1);
      if (live_windows.size() != 0 && sel < 14) begin
         w = live_windows[$urandom_range(0, live_windows.size() - 1)];
         if (sel >= 11 && sel <= 12) return w + addr_type'($urandom_range(1, WINDOW_BYTES - 1));
         if (sel == 13) return model_base[g] + (addr_type'($urandom_range(0, 15)) << WIN_SHIFT);
         return w;
      end
      case (sel % 6)
         0: return model_base[g] + (addr_type'($urandom_range(0, 15)) << WIN_SHIFT);
         1: if (returned_bases.size() != 0)
               return returned_bases[$urandom_range(0, returned_bases.size() - 1)];
         2: return model_base[g] + addr_type'(GROUP_SPAN);
         3: return addr_type'($urandom_range(0, 32'h000F_FFFF));
         default: ;
      endcase
      return random_addr();
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("ERROR: result %0d %s: got 0x%0h expected 0x%0h", rsp_index, what, got, want);
      error_count++;
   endtask

   // Drive one request, wait for its transfer, then log what it should return.
   task automatic send_window_op(input req_type r);
      rsp_type p;
      int      gap;
      if (!no_gaps) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
               @(negedge clock);
               req_valid <= 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
         burst_left--;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      p = predict_window_op(r);
      pending_rsp.push_back(p);
      last_status = p.status;
      if (p.status == ST_OK && r.mode == MODE_ACQUIRE) live_windows.push_back(p.window_addr);
      if (p.status == ST_OK && r.mode == MODE_RELEASE) begin
         for (int k = 0; k < live_windows.size(); k++) begin
            if (live_windows[k] == r.release_addr) begin
               live_windows.delete(k);
               break;
            end
         end
      end
      if (p.freed_base != '0) begin
         returned_bases.push_back(p.freed_base);
         if (returned_bases.size() > 16) void'(returned_bases.pop_front());
      end
   endtask

   task automatic req_idle();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic drain_live();
      addr_type snapshot[$];
      snapshot = live_windows;
      foreach (snapshot[k]) send_window_op(release_req(snapshot[k]));
   endtask

   task automatic test_no_base();
      send_window_op(acquire_req(1'b0, '0));
      send_window_op(acquire_req(1'b1, '0));
   endtask

   task automatic test_first_acquire();
      send_window_op(acquire_req(1'b0, BASE_A));
      send_window_op(acquire_req(1'b1, random_addr()));
      send_window_op(acquire_req(1'b1, random_addr()));
   endtask

   task automatic test_release_cases();
      addr_type win;
      win = addr_type'(WINDOW_BYTES);
      send_window_op(release_req(BASE_A + win));
      send_window_op(release_req(BASE_A + win));
      send_window_op(release_req(BASE_A + 2 * win + 48'h80));
      send_window_op(release_req(48'h0000_0000_1000));
      send_window_op(release_req(BASE_A + addr_type'(GROUP_SPAN)));
      send_window_op(release_req('1));
   endtask

   task automatic test_group0_emptied();
      send_window_op(release_req(BASE_A));
      send_window_op(release_req(BASE_A + 2 * addr_type'(WINDOW_BYTES)));
      send_window_op(acquire_req(1'b0, random_addr()));
   endtask

   // Stall the result side for a long stretch while requests keep coming.
   task automatic test_backpressure();
      hold_requests++;
      no_gaps = 1'b1;
      for (int n = 0; n < 16; n++) begin
         if (n % 3 == 2) send_window_op(release_req(pick_release_addr()));
         else send_window_op(acquire_req(1'($urandom_range(0, 1)), pick_offer()));
      end
      no_gaps = 1'b0;
   endtask

   task automatic test_random_mix();
      int acquire_pct;
      acquire_pct = 60;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // swing between filling and emptying phases to reach full and empty groups
         if (n % 128 == 0) acquire_pct = $urandom_range(25, 80);
         if ($urandom_range(0, 99) < acquire_pct)
            send_window_op(acquire_req($urandom_range(0, 3) == 0, pick_offer()));
         else
            send_window_op(release_req(pick_release_addr()));
      end
   endtask

   task automatic test_exhaust();
      int n;
      drain_live();
      for (n = 0; n < SLOTS_PER_GROUP - 1; n++) send_window_op(acquire_req(1'b0, pick_offer()));
      // with only the reserved slot left, this lands in the next group
      send_window_op(acquire_req(1'b0, TOP_BASE));
      n = 0;
      while (last_status != ST_NO_SLOT && n < 200) begin
         send_window_op(acquire_req(1'($urandom_range(0, 1)), pick_offer()));
         n++;
      end
      send_window_op(acquire_req(1'b1, '0));
      send_window_op(acquire_req(1'b0, random_addr()));
      // wrapped windows of the top group cannot be released by their address
      for (n = 0; n < 8; n++) send_window_op(release_req(addr_type'(n) << WIN_SHIFT));
      drain_live();
   endtask

   initial begin : rsp_side
      ready_style_type style;
      int              style_left;
      int              hold_left;
      int              holds_seen;
      style      = RDY_ALWAYS;
      style_left = 0;
      hold_left  = 0;
      holds_seen = 0;
      forever begin
         @(negedge clock);
         if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left  = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (style_left == 0) begin
               style      = ready_style_type'($urandom_range(0, 3));
               style_left = $urandom_range(32, 256);
            end
            style_left--;
            case (style)
               RDY_ALWAYS: rsp_ready <= 1'b1;
               RDY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               RDY_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:    rsp_ready <= (cycle_count % 5) < 3;
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected transfer", 64'(rsp_data), '0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", 64'(rsp_data.status), 64'(want.status));
            if (rsp_data.window_addr !== want.window_addr)
               report_mismatch("window_addr", 64'(rsp_data.window_addr), 64'(want.window_addr));
            if (rsp_data.freed_base !== want.freed_base)
               report_mismatch("freed_base", 64'(rsp_data.freed_base), 64'(want.freed_base));
            if (rsp_data.base_consumed !== want.base_consumed)
               report_mismatch("base_consumed", 64'(rsp_data.base_consumed),
                               64'(want.base_consumed));
         end
         rsp_index++;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_no_base();
      test_first_acquire();
      test_release_cases();
      test_group0_emptied();
      test_backpressure();
      test_random_mix();
      test_exhaust();
      req_idle();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
